@@ rtl/base64_stream_decoder_unit_macros.svh @@
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// Both macros sample on clk and are disabled while rst_n is low.
`define B64D_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define B64D_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/b64d_pkg.sv @@
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int QueueDepth = 2;

    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChEquals  = 8'h3D;

    typedef struct packed {
        logic [5:0] sextet;
        logic       alpha;
        logic       equals;
        logic       newline;
        logic       restart;
    } b64d_item_t;

    function automatic b64d_item_t b64d_classify(input logic [7:0] c, input logic rs);
        b64d_item_t it;
        it.sextet  = '0;
        it.alpha   = 1'b1;
        it.equals  = (c == ChEquals);
        it.newline = (c == ChNewline);
        it.restart = rs;
        if (c >= 8'h41 && c <= 8'h5A) begin
            it.sextet = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            it.sextet = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            it.sextet = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            it.sextet = 6'd62;
        end else if (c == 8'h2F) begin
            it.sextet = 6'd63;
        end else begin
            it.alpha = 1'b0;
        end
        return it;
    endfunction

endpackage

@@ rtl/b64d_ifs.sv @@
`timescale 1ns / 1ps

interface b64d_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink (input valid, input in_byte, input restart, output ready);
endinterface

interface b64d_item_if;
    logic                valid;
    logic                ready;
    b64d_pkg::b64d_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface b64d_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       finished;
    logic       error;

    modport source (output valid, output out_byte, output out_valid, output finished,
                    output error, input ready);
    modport sink (input valid, input out_byte, input out_valid, input finished,
                  input error, output ready);
endinterface

@@ rtl/b64d_front.sv @@
`timescale 1ns / 1ps

module b64d_front (
    b64d_text_if.sink   text,
    b64d_item_if.source push
);
    import b64d_pkg::*;

    assign push.valid = text.valid;
    assign push.item  = b64d_classify(text.in_byte, text.restart);
    assign text.ready = push.ready;

endmodule

@@ rtl/b64d_queue.sv @@
`timescale 1ns / 1ps

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QueueDepth
) (
    input logic         clk,
    input logic         rst_n,
    b64d_item_if.sink   push,
    b64d_item_if.source pop
);
    import b64d_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    b64d_item_t mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push.ready = (count_reg != CntW'(DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.item   = mem[rd_ptr_reg];
    assign do_push    = push.valid && push.ready;
    assign do_pop     = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/b64d_back.sv @@
`timescale 1ns / 1ps

module b64d_back (
    input logic         clk,
    input logic         rst_n,
    b64d_item_if.sink   pop,
    b64d_data_if.source data
);
    import b64d_pkg::*;

    logic [1:0] slot_reg, slot_next;
    logic [5:0] held_reg, held_next;
    logic       ignore_reg, ignore_next;
    logic [2:0] head_eq_reg, head_eq_next;
    logic       at_head_reg, at_head_next;
    logic       pad_reg, pad_next;
    logic       end_reg, end_next;
    logic       fault_reg, fault_next;

    logic       obeat_reg;
    logic [7:0] byte_reg, byte_next;
    logic       bvalid_reg, bvalid_next;
    logic       take;

    assign pop.ready = !obeat_reg || data.ready;
    assign take      = pop.valid && pop.ready;

    always_comb
    begin
        logic handled;
        b64d_item_t it;
        it           = pop.item;
        handled      = 1'b0;
        slot_next    = slot_reg;
        held_next    = held_reg;
        ignore_next  = ignore_reg;
        head_eq_next = head_eq_reg;
        at_head_next = at_head_reg;
        pad_next     = pad_reg;
        end_next     = end_reg;
        fault_next   = fault_reg;
        byte_next    = '0;
        bvalid_next  = 1'b0;

        if (it.restart)
        begin
            slot_next    = '0;
            held_next    = '0;
            ignore_next  = 1'b0;
            head_eq_next = '0;
            at_head_next = 1'b1;
            pad_next     = 1'b0;
            end_next     = 1'b0;
            fault_next   = 1'b0;
        end

        if (!fault_next && !end_next)
        begin
            if (at_head_next)
            begin
                if (it.equals)
                begin
                    head_eq_next = head_eq_next + 1'b1;
                    if (head_eq_next >= 3'd4)
                    begin
                        end_next     = 1'b1;
                        at_head_next = 1'b0;
                    end
                    handled = 1'b1;
                end
                else
                begin
                    at_head_next = 1'b0;
                    head_eq_next = '0;
                    if (pad_next)
                    begin
                        fault_next = 1'b1;
                        handled    = 1'b1;
                    end
                end
            end
            if (!handled && ignore_next)
            begin
                if (it.newline)
                begin
                    ignore_next  = 1'b0;
                    at_head_next = 1'b1;
                    head_eq_next = '0;
                end
                handled = 1'b1;
            end
            if (!handled)
            begin
                if (it.newline)
                begin
                    if (slot_next == 2'd0)
                    begin
                        at_head_next = 1'b1;
                        head_eq_next = '0;
                    end
                    else
                    begin
                        fault_next = 1'b1;
                    end
                end
                else if (slot_next == 2'd0)
                begin
                    if (it.alpha)
                    begin
                        held_next = it.sextet;
                        slot_next = 2'd1;
                    end
                end
                else if (slot_next == 2'd1)
                begin
                    if (it.equals)
                    begin
                        fault_next = 1'b1;
                    end
                    else if (it.alpha)
                    begin
                        byte_next   = {held_next, it.sextet[5:4]};
                        bvalid_next = 1'b1;
                        held_next   = it.sextet;
                        slot_next   = 2'd2;
                    end
                end
                else
                begin
                    if (it.equals)
                    begin
                        pad_next    = 1'b1;
                        ignore_next = 1'b1;
                        slot_next   = 2'd0;
                    end
                    else if (it.alpha)
                    begin
                        if (slot_next == 2'd2)
                        begin
                            byte_next = {held_next[3:0], it.sextet[5:2]};
                            slot_next = 2'd3;
                        end
                        else
                        begin
                            byte_next = {held_next[1:0], it.sextet};
                            slot_next = 2'd0;
                        end
                        bvalid_next = 1'b1;
                        held_next   = it.sextet;
                    end
                end
            end
        end

        if (fault_next)
        begin
            byte_next   = '0;
            bvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            held_reg    <= '0;
            ignore_reg  <= 1'b0;
            head_eq_reg <= '0;
            at_head_reg <= 1'b1;
            pad_reg     <= 1'b0;
            end_reg     <= 1'b0;
            fault_reg   <= 1'b0;
            obeat_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                slot_reg    <= slot_next;
                held_reg    <= held_next;
                ignore_reg  <= ignore_next;
                head_eq_reg <= head_eq_next;
                at_head_reg <= at_head_next;
                pad_reg     <= pad_next;
                end_reg     <= end_next;
                fault_reg   <= fault_next;
                obeat_reg   <= 1'b1;
            end
            else if (data.ready)
            begin
                obeat_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
        end
    end

    assign data.valid     = obeat_reg;
    assign data.out_byte  = byte_reg;
    assign data.out_valid = bvalid_reg;
    assign data.finished  = end_reg;
    assign data.error     = fault_reg;

endmodule

@@ rtl/base64_stream_decoder_unit.sv @@
// Channel | Direction | Beat contents
// text    | in        | in_byte, restart
// data    | out       | out_byte, out_valid, finished, error
//
// Every text beat yields exactly one data beat, in order.
// Sustained rate is one beat per cycle while data is ready; a beat is held in the
// queue, then in the decoder's output register. The front classifies each character
// and a small queue decouples it from the decoder, whose state and output register
// advance only when a beat is taken. Reset is asynchronous and active low; a stalled
// data port stops the decoder, and the front stalls once the queue is full.
`timescale 1ns / 1ps

`include "base64_stream_decoder_unit_macros.svh"

module base64_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = b64d_pkg::QueueDepth
) (
    input logic         clk,
    input logic         rst_n,
    b64d_text_if.sink   text,
    b64d_data_if.source data
);
    import b64d_pkg::*;

    b64d_item_if push ();
    b64d_item_if mid ();

    b64d_front u_front (
        .text (text),
        .push (push.source)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push.sink),
        .pop   (mid.source)
    );

    b64d_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .pop   (mid.sink),
        .data  (data)
    );

    `B64D_ASSERT(a_error_masks_byte, !(data.valid && data.error) || (!data.out_valid && data.out_byte == 8'h00), "decoded byte reported while error is set")
    `B64D_ASSERT_NEXT(a_push_fills_queue, text.valid && text.ready, mid.valid, "accepted text beat did not reach the queue")
    `B64D_ASSERT(a_empty_queue_ready, mid.valid || text.ready, "front stalled with an empty queue")

endmodule
